### rtl/selective_repeat_arq_control_top_assert.svh
// Assertion macros for the ARQ control datapath module.
// Each expects clk and arst_n in scope.
`ifndef SELECTIVE_REPEAT_ARQ_CONTROL_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_ARQ_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication.
`define SRARQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SRARQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/srarq_pkg.sv
package srarq_pkg;

	localparam int MAX_SEQ_NUM = 15;
	localparam int SEQ_MOD     = MAX_SEQ_NUM + 1;
	localparam int WINDOW      = 8;

	localparam int SEQ_W  = 4;
	localparam int SLOT_W = 3;
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// events
	localparam logic [2:0] CMD_PKT   = 3'd0;
	localparam logic [2:0] CMD_LINK  = 3'd1;
	localparam logic [2:0] CMD_FRAME = 3'd2;
	localparam logic [2:0] CMD_DTMO  = 3'd3;
	localparam logic [2:0] CMD_ATMO  = 3'd4;

	// received frame kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_NAK  = 2'd2;

	// result actions
	localparam logic [2:0] ACT_DATA    = 3'd0;
	localparam logic [2:0] ACT_ACK     = 3'd1;
	localparam logic [2:0] ACT_NAK     = 3'd2;
	localparam logic [2:0] ACT_STORE   = 3'd3;
	localparam logic [2:0] ACT_DELIVER = 3'd4;
	localparam logic [2:0] ACT_STOP    = 3'd5;
	localparam logic [2:0] ACT_STATUS  = 3'd6;

	// datapath emit operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_DATA_NEW = 4'd1;
	localparam logic [3:0] OP_RESEND   = 4'd2;
	localparam logic [3:0] OP_TMO      = 4'd3;
	localparam logic [3:0] OP_ACK      = 4'd4;
	localparam logic [3:0] OP_NAK      = 4'd5;
	localparam logic [3:0] OP_STORE    = 4'd6;
	localparam logic [3:0] OP_DELIVER  = 4'd7;
	localparam logic [3:0] OP_STOP     = 4'd8;
	localparam logic [3:0] OP_STATUS   = 4'd9;

	typedef struct packed {
		logic       load;
		logic       set_link;
		logic       fire;
		logic [3:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic       emit_ok;
		logic [2:0] cmd;
		logic       good;
		logic [1:0] kind;
		logic       cnt_lt_win;
		logic       nak_allowed;
		logic       seq_ne_rle;
		logic       store_ok;
		logic       deliver_ok;
		logic       resend_ok;
		logic       retire_ok;
	} dp_sts_t;

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] x);
		return SEQ_W'((32'(x) + 32'd1) % SEQ_MOD);
	endfunction

	function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] x);
		return SEQ_W'((32'(x) + 32'(MAX_SEQ_NUM)) % SEQ_MOD);
	endfunction

	function automatic logic [SEQ_W-1:0] seq_add_win(input logic [SEQ_W-1:0] x);
		return SEQ_W'((32'(x) + 32'(WINDOW)) % SEQ_MOD);
	endfunction

	// circular lo <= x < hi
	function automatic logic in_window(input logic [SEQ_W-1:0] lo,
			input logic [SEQ_W-1:0] x, input logic [SEQ_W-1:0] hi);
		return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
			((x < hi) && (hi < lo));
	endfunction

endpackage

### rtl/srarq_ctrl.sv
module srarq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  srarq_pkg::dp_sts_t sts,
	output srarq_pkg::dp_cmd_t dcmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_SEND_NEW = 4'd2;
	localparam logic [3:0] S_NAK      = 4'd3;
	localparam logic [3:0] S_STORE    = 4'd4;
	localparam logic [3:0] S_DELIVER  = 4'd5;
	localparam logic [3:0] S_RESEND   = 4'd6;
	localparam logic [3:0] S_RETIRE   = 4'd7;
	localparam logic [3:0] S_SEND_TMO = 4'd8;
	localparam logic [3:0] S_SEND_ACK = 4'd9;
	localparam logic [3:0] S_STATUS   = 4'd10;

	logic [3:0] state_q, state_d;
	logic [srarq_pkg::CNT_W-1:0] n_q, n_d;
	logic n_lt_win;

	assign in_stall = (state_q != S_IDLE);
	assign n_lt_win = (n_q < srarq_pkg::CNT_W'(srarq_pkg::WINDOW));

	// issue each op once the output register can take it; idle, dispatch, loop exits and refused steps do not wait
	always_comb begin
		state_d       = state_q;
		n_d           = n_q;
		dcmd.load     = 1'b0;
		dcmd.set_link = 1'b0;
		dcmd.fire     = 1'b0;
		dcmd.op       = srarq_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dcmd.load = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				n_d = '0;
				case (sts.cmd)
					srarq_pkg::CMD_PKT:
						state_d = sts.cnt_lt_win ? S_SEND_NEW : S_STATUS;
					srarq_pkg::CMD_LINK: begin
						dcmd.set_link = 1'b1;
						state_d       = S_STATUS;
					end
					srarq_pkg::CMD_FRAME: begin
						if (!sts.good) begin
							state_d = sts.nak_allowed ? S_NAK : S_STATUS;
						end else begin
							case (sts.kind)
								srarq_pkg::KIND_DATA:
									state_d = (sts.seq_ne_rle && sts.nak_allowed) ?
										S_NAK : S_STORE;
								srarq_pkg::KIND_NAK: state_d = S_RESEND;
								default: state_d = S_RETIRE;
							endcase
						end
					end
					srarq_pkg::CMD_DTMO: state_d = S_SEND_TMO;
					srarq_pkg::CMD_ATMO: state_d = S_SEND_ACK;
					default: state_d = S_STATUS;
				endcase
			end
			S_SEND_NEW: begin
				dcmd.op = srarq_pkg::OP_DATA_NEW;
				if (sts.emit_ok) begin
					dcmd.fire = 1'b1;
					state_d   = S_STATUS;
				end
			end
			S_NAK: begin
				dcmd.op = srarq_pkg::OP_NAK;
				if (sts.emit_ok) begin
					dcmd.fire = 1'b1;
					state_d   = sts.good ? S_STORE : S_STATUS;
				end
			end
			S_STORE: begin
				if (sts.store_ok) begin
					dcmd.op = srarq_pkg::OP_STORE;
					if (sts.emit_ok) begin
						dcmd.fire = 1'b1;
						state_d   = S_DELIVER;
					end
				end else begin
					state_d = S_RETIRE;
				end
			end
			S_DELIVER: begin
				if (n_lt_win && sts.deliver_ok) begin
					dcmd.op = srarq_pkg::OP_DELIVER;
					if (sts.emit_ok) begin
						dcmd.fire = 1'b1;
						n_d       = n_q + 1'b1;
					end
				end else begin
					n_d     = '0;
					state_d = S_RETIRE;
				end
			end
			S_RESEND: begin
				if (sts.resend_ok) begin
					dcmd.op = srarq_pkg::OP_RESEND;
					if (sts.emit_ok) begin
						dcmd.fire = 1'b1;
						state_d   = S_RETIRE;
					end
				end else begin
					state_d = S_RETIRE;
				end
			end
			S_RETIRE: begin
				if (n_lt_win && sts.retire_ok) begin
					dcmd.op = srarq_pkg::OP_STOP;
					if (sts.emit_ok) begin
						dcmd.fire = 1'b1;
						n_d       = n_q + 1'b1;
					end
				end else begin
					state_d = S_STATUS;
				end
			end
			S_SEND_TMO: begin
				dcmd.op = srarq_pkg::OP_TMO;
				if (sts.emit_ok) begin
					dcmd.fire = 1'b1;
					state_d   = S_STATUS;
				end
			end
			S_SEND_ACK: begin
				dcmd.op = srarq_pkg::OP_ACK;
				if (sts.emit_ok) begin
					dcmd.fire = 1'b1;
					state_d   = S_STATUS;
				end
			end
			S_STATUS: begin
				dcmd.op = srarq_pkg::OP_STATUS;
				if (sts.emit_ok) begin
					dcmd.fire = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
		end
	end

endmodule

### rtl/srarq_dp.sv
module srarq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  srarq_pkg::dp_cmd_t dcmd,
	output srarq_pkg::dp_sts_t sts,
	input  logic [2:0]        cmd,
	input  logic              frame_good,
	input  logic [1:0]        frame_kind,
	input  logic [3:0]        frame_seq,
	input  logic [3:0]        rx_ack,
	input  logic [2:0]        timer_slot,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        action,
	output logic [3:0]        seq_num,
	output logic [3:0]        ack_num,
	output logic [2:0]        slot,
	output logic              network_enable,
	output logic              last
);

	localparam int SEQ_W  = srarq_pkg::SEQ_W;
	localparam int SLOT_W = srarq_pkg::SLOT_W;
	localparam int CNT_W  = srarq_pkg::CNT_W;

	// latched event
	logic [2:0]        cmd_q;
	logic              good_q;
	logic [1:0]        kind_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  ack_q;
	logic [SLOT_W-1:0] tslot_q;

	// window state
	logic [SEQ_W-1:0]  sle_q, sn_q, rle_q, rue_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [srarq_pkg::WINDOW-1:0] map_q;
	logic              nak_allowed_q, link_q;

	// output register
	logic              out_valid_q;
	logic [2:0]        action_q;
	logic [SEQ_W-1:0]  seq_num_q, ack_num_q;
	logic [SLOT_W-1:0] slot_q;
	logic              ne_q, last_q;

	logic              emit_ok, ne;
	logic [SEQ_W-1:0]  piggy, resend_seq, tmo_base, tmo_seq;
	logic [2:0]        nx_action;
	logic [SEQ_W-1:0]  nx_seq, nx_ack;
	logic              nx_ne, nx_last;

	assign emit_ok    = !out_valid_q || !out_stall;
	assign piggy      = srarq_pkg::seq_dec(rle_q);
	assign resend_seq = srarq_pkg::seq_inc(ack_q);
	assign tmo_base   = SEQ_W'(tslot_q);
	// stale timer slot: resend the frame one window further on
	assign tmo_seq    = srarq_pkg::in_window(sle_q, tmo_base, sn_q) ?
		tmo_base : srarq_pkg::seq_add_win(tmo_base);
	assign ne         = (cnt_q < CNT_W'(srarq_pkg::WINDOW)) && link_q;

	always_comb begin
		sts.emit_ok     = emit_ok;
		sts.cmd         = cmd_q;
		sts.good        = good_q;
		sts.kind        = kind_q;
		sts.cnt_lt_win  = (cnt_q < CNT_W'(srarq_pkg::WINDOW));
		sts.nak_allowed = nak_allowed_q;
		sts.seq_ne_rle  = (seq_q != rle_q);
		sts.store_ok    = srarq_pkg::in_window(rle_q, seq_q, rue_q) &&
			!map_q[seq_q[SLOT_W-1:0]];
		sts.deliver_ok  = map_q[rle_q[SLOT_W-1:0]];
		sts.resend_ok   = srarq_pkg::in_window(sle_q, resend_seq, sn_q);
		sts.retire_ok   = srarq_pkg::in_window(sle_q, ack_q, sn_q);
	end

	always_comb begin
		nx_action = srarq_pkg::ACT_STATUS;
		nx_seq    = '0;
		nx_ack    = '0;
		nx_ne     = 1'b0;
		nx_last   = 1'b0;
		case (dcmd.op)
			srarq_pkg::OP_DATA_NEW: begin
				nx_action = srarq_pkg::ACT_DATA;
				nx_seq    = sn_q;
				nx_ack    = piggy;
			end
			srarq_pkg::OP_RESEND: begin
				nx_action = srarq_pkg::ACT_DATA;
				nx_seq    = resend_seq;
				nx_ack    = piggy;
			end
			srarq_pkg::OP_TMO: begin
				nx_action = srarq_pkg::ACT_DATA;
				nx_seq    = tmo_seq;
				nx_ack    = piggy;
			end
			srarq_pkg::OP_ACK: begin
				nx_action = srarq_pkg::ACT_ACK;
				nx_ack    = piggy;
			end
			srarq_pkg::OP_NAK: begin
				nx_action = srarq_pkg::ACT_NAK;
				nx_ack    = piggy;
			end
			srarq_pkg::OP_STORE: begin
				nx_action = srarq_pkg::ACT_STORE;
				nx_seq    = seq_q;
			end
			srarq_pkg::OP_DELIVER: begin
				nx_action = srarq_pkg::ACT_DELIVER;
				nx_seq    = rle_q;
			end
			srarq_pkg::OP_STOP: begin
				nx_action = srarq_pkg::ACT_STOP;
				nx_seq    = sle_q;
			end
			default: begin
				nx_ne   = ne;
				nx_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q   <= cmd;
			good_q  <= frame_good;
			kind_q  <= frame_kind;
			seq_q   <= SEQ_W'(32'(frame_seq) % srarq_pkg::SEQ_MOD);
			ack_q   <= SEQ_W'(32'(rx_ack) % srarq_pkg::SEQ_MOD);
			tslot_q <= SLOT_W'(32'(timer_slot) % srarq_pkg::WINDOW);
		end
		if (dcmd.fire) begin
			action_q  <= nx_action;
			seq_num_q <= nx_seq;
			ack_num_q <= nx_ack;
			slot_q    <= nx_seq[SLOT_W-1:0];
			ne_q      <= nx_ne;
			last_q    <= nx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			sle_q         <= '0;
			sn_q          <= '0;
			rle_q         <= '0;
			rue_q         <= SEQ_W'(srarq_pkg::WINDOW % srarq_pkg::SEQ_MOD);
			cnt_q         <= '0;
			map_q         <= '0;
			nak_allowed_q <= 1'b1;
			link_q        <= 1'b0;
		end else begin
			if (dcmd.fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (dcmd.set_link) begin
				link_q <= 1'b1;
			end
			if (dcmd.fire) begin
				case (dcmd.op)
					srarq_pkg::OP_DATA_NEW: begin
						cnt_q  <= cnt_q + 1'b1;
						sn_q   <= srarq_pkg::seq_inc(sn_q);
						link_q <= 1'b0;
					end
					srarq_pkg::OP_RESEND, srarq_pkg::OP_TMO, srarq_pkg::OP_ACK: begin
						link_q <= 1'b0;
					end
					srarq_pkg::OP_NAK: begin
						link_q        <= 1'b0;
						nak_allowed_q <= 1'b0;
					end
					srarq_pkg::OP_STORE: begin
						map_q[seq_q[SLOT_W-1:0]] <= 1'b1;
					end
					srarq_pkg::OP_DELIVER: begin
						nak_allowed_q            <= 1'b1;
						map_q[rle_q[SLOT_W-1:0]] <= 1'b0;
						rle_q                    <= srarq_pkg::seq_inc(rle_q);
						rue_q                    <= srarq_pkg::seq_inc(rue_q);
					end
					srarq_pkg::OP_STOP: begin
						// hold at zero
						if (cnt_q != '0) begin
							cnt_q <= cnt_q - 1'b1;
						end
						sle_q <= srarq_pkg::seq_inc(sle_q);
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = action_q;
	assign seq_num        = seq_num_q;
	assign ack_num        = ack_num_q;
	assign slot           = slot_q;
	assign network_enable = ne_q;
	assign last           = last_q;

`include "selective_repeat_arq_control_top_assert.svh"

	`SRARQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(srarq_pkg::WINDOW), "buffered count above window")
	`SRARQ_ASSERT_NOW(a_fire_room, dcmd.fire, emit_ok, "result issued over a waiting result")
	`SRARQ_ASSERT_NEXT(a_nak_flags, dcmd.fire && (dcmd.op == srarq_pkg::OP_NAK), !nak_allowed_q && !link_q, "nak did not clear flags")
	`SRARQ_ASSERT_NOW(a_rx_width, 1'b1, rue_q == srarq_pkg::seq_add_win(rle_q), "receive window width lost")

endmodule

### rtl/selective_repeat_arq_control_top.sv
// Selective-repeat ARQ control engine: each accepted event (packet ready, link ready,
// frame received, data timeout, ack timeout) yields a run of result transactions ending
// in a status item with last set. Each event is accepted, decoded, then issues one result
// per step, with an extra step for each loop exit or refused store or resend; the delivery
// and ack-retire loops step one frame per cycle through the window state while the output
// is not stalled. in_stall stays high until the status item has been issued.
module selective_repeat_arq_control_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic       frame_good,
	input  logic [1:0] frame_kind,
	input  logic [3:0] frame_seq,
	input  logic [3:0] rx_ack,
	input  logic [2:0] timer_slot,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] action,
	output logic [3:0] seq_num,
	output logic [3:0] ack_num,
	output logic [2:0] slot,
	output logic       network_enable,
	output logic       last
);

	srarq_pkg::dp_cmd_t dcmd;
	srarq_pkg::dp_sts_t sts;

	srarq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.dcmd     (dcmd)
	);

	srarq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dcmd           (dcmd),
		.sts            (sts),
		.cmd            (cmd),
		.frame_good     (frame_good),
		.frame_kind     (frame_kind),
		.frame_seq      (frame_seq),
		.rx_ack         (rx_ack),
		.timer_slot     (timer_slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action         (action),
		.seq_num        (seq_num),
		.ack_num        (ack_num),
		.slot           (slot),
		.network_enable (network_enable),
		.last           (last)
	);

endmodule

### dv/selective_repeat_arq_control_tb.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEQ_W       = srarq_pkg::SEQ_W;
	localparam int SLOT_W      = srarq_pkg::SLOT_W;
	localparam int SEQ_MOD     = srarq_pkg::SEQ_MOD;
	localparam int WINDOW      = srarq_pkg::WINDOW;
	localparam int MAX_SEQ_NUM = srarq_pkg::MAX_SEQ_NUM;

	localparam int TOTAL_ITEMS = 420;
	localparam int QUIET_ITEMS = 60;
	localparam int LONG_HOLD   = 400;
	localparam int HOLD_AFTER  = 300;
	localparam int DRAIN       = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [2:0]        op;
		logic              good;
		logic [1:0]        kind;
		logic [SEQ_W-1:0]  seq;
		logic [SEQ_W-1:0]  ack;
		logic [SLOT_W-1:0] tslot;
	} link_event_t;

	typedef struct packed {
		logic [2:0]        action;
		logic [SEQ_W-1:0]  seq;
		logic [SEQ_W-1:0]  ack;
		logic [SLOT_W-1:0] slot;
		logic              ne;
		logic              last;
	} arq_result_t;

	typedef struct {
		link_event_t ev;
		int          n_typed;
		arq_result_t r0;
		arq_result_t r1;
	} stim_row_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_stall;
	logic [2:0]        cmd            = '0;
	logic              frame_good     = 1'b0;
	logic [1:0]        frame_kind     = '0;
	logic [SEQ_W-1:0]  frame_seq      = '0;
	logic [SEQ_W-1:0]  rx_ack         = '0;
	logic [SLOT_W-1:0] timer_slot     = '0;
	logic              out_valid;
	logic              out_stall      = 1'b0;
	logic [2:0]        action;
	logic [SEQ_W-1:0]  seq_num;
	logic [SEQ_W-1:0]  ack_num;
	logic [SLOT_W-1:0] slot;
	logic              network_enable;
	logic              last;

	selective_repeat_arq_control_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.frame_good     (frame_good),
		.frame_kind     (frame_kind),
		.frame_seq      (frame_seq),
		.rx_ack         (rx_ack),
		.timer_slot     (timer_slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action         (action),
		.seq_num        (seq_num),
		.ack_num        (ack_num),
		.slot           (slot),
		.network_enable (network_enable),
		.last           (last)
	);

	always #1 clk = ~clk;

	// window state of the predicted engine
	logic [SEQ_W-1:0]  snd_lo;
	logic [SEQ_W-1:0]  snd_next;
	logic [SEQ_W-1:0]  rcv_lo;
	logic [SEQ_W-1:0]  rcv_hi;
	int                buf_cnt;
	logic [WINDOW-1:0] got_map;
	bit                nak_ok;
	bit                link_up;

	arq_result_t pending_results[$];
	stim_row_t   stim_rows[$];

	int  faults      = 0;
	int  checked     = 0;
	int  accepted    = 0;
	int  n_deliver   = 0;
	int  n_stop      = 0;
	int  cycles      = 0;
	int  hold_left   = 0;
	bit  long_done   = 1'b0;
	logic quiet      = 1'b0;

	function automatic logic [SEQ_W-1:0] wrap_seq(int v);
		return SEQ_W'(v % SEQ_MOD);
	endfunction

	// circular membership in [lo, hi)
	function automatic bit seq_between(int lo, int x, int hi);
		return ((x - lo + SEQ_MOD) % SEQ_MOD) < ((hi - lo + SEQ_MOD) % SEQ_MOD);
	endfunction

	function automatic arq_result_t res(int act, int sq, int ak, int sl, int ne, int lst);
		arq_result_t r;
		r.action = 3'(act);
		r.seq    = SEQ_W'(sq);
		r.ack    = SEQ_W'(ak);
		r.slot   = SLOT_W'(sl);
		r.ne     = 1'(ne);
		r.last   = 1'(lst);
		return r;
	endfunction

	function automatic link_event_t mk_ev(int op, int good, int kind, int sq, int ak, int ts);
		link_event_t e;
		e.op    = 3'(op);
		e.good  = 1'(good);
		e.kind  = 2'(kind);
		e.seq   = SEQ_W'(sq);
		e.ack   = SEQ_W'(ak);
		e.tslot = SLOT_W'(ts);
		return e;
	endfunction

	function automatic int piggy_ack();
		return (int'(rcv_lo) + MAX_SEQ_NUM) % SEQ_MOD;
	endfunction

	function automatic void reset_window_state();
		snd_lo   = '0;
		snd_next = '0;
		rcv_lo   = '0;
		rcv_hi   = wrap_seq(WINDOW);
		buf_cnt  = 0;
		got_map  = '0;
		nak_ok   = 1'b1;
		link_up  = 1'b0;
	endfunction

	function automatic void expect_data(int s);
		s = s % SEQ_MOD;
		pending_results.push_back(res(srarq_pkg::ACT_DATA, s, piggy_ack(), s % WINDOW, 0, 0));
		link_up = 1'b0;
	endfunction

	function automatic void expect_ctrl(logic [2:0] act);
		pending_results.push_back(res(act, 0, piggy_ack(), 0, 0, 0));
		if (act == srarq_pkg::ACT_NAK)
			nak_ok = 1'b0;
		link_up = 1'b0;
	endfunction

	function automatic void predict_event(link_event_t ev);
		int s;
		int a;
		int n;
		s = int'(ev.seq) % SEQ_MOD;
		a = int'(ev.ack) % SEQ_MOD;
		case (ev.op)
			srarq_pkg::CMD_PKT: begin
				if (buf_cnt < WINDOW) begin
					buf_cnt++;
					expect_data(snd_next);
					snd_next = wrap_seq(snd_next + 1);
				end
			end
			srarq_pkg::CMD_LINK: link_up = 1'b1;
			srarq_pkg::CMD_FRAME: begin
				if (!ev.good) begin
					if (nak_ok)
						expect_ctrl(srarq_pkg::ACT_NAK);
				end else begin
					if (ev.kind == srarq_pkg::KIND_DATA) begin
						if (s != int'(rcv_lo) && nak_ok)
							expect_ctrl(srarq_pkg::ACT_NAK);
						if (seq_between(rcv_lo, s, rcv_hi) && !got_map[s % WINDOW]) begin
							got_map[s % WINDOW] = 1'b1;
							pending_results.push_back(res(srarq_pkg::ACT_STORE, s, 0,
								s % WINDOW, 0, 0));
							// deliver the in-order run, at most one window
							for (n = 0; n < WINDOW && got_map[int'(rcv_lo) % WINDOW]; n++) begin
								pending_results.push_back(res(srarq_pkg::ACT_DELIVER, rcv_lo, 0,
									int'(rcv_lo) % WINDOW, 0, 0));
								nak_ok = 1'b1;
								got_map[int'(rcv_lo) % WINDOW] = 1'b0;
								rcv_lo = wrap_seq(rcv_lo + 1);
								rcv_hi = wrap_seq(rcv_hi + 1);
							end
						end
					end else if (ev.kind == srarq_pkg::KIND_NAK) begin
						if (seq_between(snd_lo, (a + 1) % SEQ_MOD, snd_next))
							expect_data(a + 1);
					end
					// retire everything up to and including the ack, any kind
					for (n = 0; n < WINDOW && seq_between(snd_lo, a, snd_next); n++) begin
						if (buf_cnt > 0)
							buf_cnt--;
						pending_results.push_back(res(srarq_pkg::ACT_STOP, snd_lo, 0,
							int'(snd_lo) % WINDOW, 0, 0));
						snd_lo = wrap_seq(snd_lo + 1);
					end
				end
			end
			srarq_pkg::CMD_DTMO: begin
				s = (int'(ev.tslot) % WINDOW) % SEQ_MOD;
				if (!seq_between(snd_lo, s, snd_next))
					s = (s + WINDOW) % SEQ_MOD;
				expect_data(s);
			end
			srarq_pkg::CMD_ATMO: expect_ctrl(srarq_pkg::ACT_ACK);
			default: ;
		endcase
		pending_results.push_back(res(srarq_pkg::ACT_STATUS, 0, 0, 0,
			(buf_cnt < WINDOW && link_up) ? 1 : 0, 1));
	endfunction

	// ack aimed mostly inside the send window so frames retire
	function automatic int pick_ack();
		int outstanding;
		outstanding = (int'(snd_next) - int'(snd_lo) + SEQ_MOD) % SEQ_MOD;
		if (outstanding > 0 && $urandom_range(0, 99) < 80)
			return (int'(snd_lo) + $urandom_range(0, outstanding - 1)) % SEQ_MOD;
		return $urandom_range(0, SEQ_MOD - 1);
	endfunction

	function automatic link_event_t random_event();
		link_event_t e;
		int r;
		int outstanding;
		e = mk_ev($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 3),
			$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7));
		outstanding = (int'(snd_next) - int'(snd_lo) + SEQ_MOD) % SEQ_MOD;
		r = $urandom_range(0, 99);
		if (r < 24) begin
			e.op = srarq_pkg::CMD_PKT;
		end else if (r < 32) begin
			e.op = srarq_pkg::CMD_LINK;
		end else if (r < 56) begin
			e.op   = srarq_pkg::CMD_FRAME;
			e.good = 1'b1;
			e.kind = srarq_pkg::KIND_DATA;
			r = $urandom_range(0, 99);
			if (r < 35)
				e.seq = rcv_lo;
			else if (r < 80)
				e.seq = wrap_seq(rcv_lo + $urandom_range(0, WINDOW - 1));
			if ($urandom_range(0, 1))
				e.ack = wrap_seq(pick_ack());
			else
				e.ack = wrap_seq(snd_lo + MAX_SEQ_NUM);
		end else if (r < 70) begin
			e.op   = srarq_pkg::CMD_FRAME;
			e.good = 1'b1;
			e.kind = srarq_pkg::KIND_ACK;
			e.ack  = wrap_seq(pick_ack());
		end else if (r < 77) begin
			e.op   = srarq_pkg::CMD_FRAME;
			e.good = 1'b1;
			e.kind = srarq_pkg::KIND_NAK;
			e.ack  = wrap_seq(snd_lo + MAX_SEQ_NUM + $urandom_range(0, outstanding));
		end else if (r < 82) begin
			e.op   = srarq_pkg::CMD_FRAME;
			e.good = 1'b0;
		end else if (r < 90) begin
			e.op = srarq_pkg::CMD_DTMO;
		end else if (r < 95) begin
			e.op = srarq_pkg::CMD_ATMO;
		end else if (r < 98) begin
			e.op   = srarq_pkg::CMD_FRAME;
			e.good = 1'b1;
			e.kind = 2'd3;
			e.ack  = wrap_seq(pick_ack());
		end else begin
			e.op = 3'($urandom_range(5, 7));
		end
		return e;
	endfunction

	function automatic void note_fault(string msg);
		faults++;
		if (faults <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	function automatic void add_row(link_event_t ev, int n, arq_result_t r0, arq_result_t r1);
		stim_row_t row;
		row.ev      = ev;
		row.n_typed = n;
		row.r0      = r0;
		row.r1      = r1;
		stim_rows.push_back(row);
	endfunction

	task automatic offer(link_event_t ev);
		if (!quiet && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= ev.op;
		frame_good <= ev.good;
		frame_kind <= ev.kind;
		frame_seq  <= ev.seq;
		rx_ack     <= ev.ack;
		timer_slot <= ev.tslot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		accepted++;
	endtask

	initial begin : stimulus
		link_event_t ev;
		int base;
		reset_window_state();

		add_row(mk_ev(7, 0, 0, 0, 0, 0), 1, res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1), '0);
		add_row(mk_ev(5, 1, 3, 15, 15, 7), 1, res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1), '0);
		add_row(mk_ev(srarq_pkg::CMD_LINK, 0, 0, 0, 0, 0), 1,
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 1, 1), '0);
		add_row(mk_ev(srarq_pkg::CMD_PKT, 0, 0, 0, 0, 0), 2,
			res(srarq_pkg::ACT_DATA, 0, 15, 0, 0, 0),
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1));
		add_row(mk_ev(srarq_pkg::CMD_LINK, 0, 0, 0, 0, 0), 1,
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 1, 1), '0);
		add_row(mk_ev(srarq_pkg::CMD_ATMO, 0, 0, 0, 0, 0), 2,
			res(srarq_pkg::ACT_ACK, 0, 15, 0, 0, 0),
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1));
		// bad frame: nak once, then silence until a delivery
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 0, srarq_pkg::KIND_DATA, 5, 3, 0), 2,
			res(srarq_pkg::ACT_NAK, 0, 15, 0, 0, 0),
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1));
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 0, srarq_pkg::KIND_NAK, 0, 0, 0), 1,
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1), '0);
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 1, srarq_pkg::KIND_DATA, 0, 15, 0), 0, '0, '0);
		repeat (7) add_row(mk_ev(srarq_pkg::CMD_PKT, 0, 0, 0, 0, 0), 0, '0, '0);
		// window full: packet and link events only report status
		add_row(mk_ev(srarq_pkg::CMD_PKT, 0, 0, 0, 0, 0), 1,
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1), '0);
		add_row(mk_ev(srarq_pkg::CMD_LINK, 0, 0, 0, 0, 0), 1,
			res(srarq_pkg::ACT_STATUS, 0, 0, 0, 0, 1), '0);
		add_row(mk_ev(srarq_pkg::CMD_DTMO, 0, 0, 0, 0, 3), 0, '0, '0);
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 1, srarq_pkg::KIND_NAK, 0, 2, 0), 0, '0, '0);
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 1, 3, 0, 4, 0), 0, '0, '0);
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 1, srarq_pkg::KIND_ACK, 0, 7, 0), 0, '0, '0);
		// stale slot: send window now empty
		add_row(mk_ev(srarq_pkg::CMD_DTMO, 0, 0, 0, 0, 0), 0, '0, '0);
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 1, srarq_pkg::KIND_DATA, 3, 15, 0), 0, '0, '0);
		add_row(mk_ev(srarq_pkg::CMD_FRAME, 1, srarq_pkg::KIND_DATA, 15, 0, 7), 0, '0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			offer(stim_rows[i].ev);
			base = pending_results.size();
			predict_event(stim_rows[i].ev);
			if (stim_rows[i].n_typed != 0) begin
				while (pending_results.size() > base) void'(pending_results.pop_back());
				pending_results.push_back(stim_rows[i].r0);
				if (stim_rows[i].n_typed > 1)
					pending_results.push_back(stim_rows[i].r1);
			end
		end

		while (accepted < TOTAL_ITEMS) begin
			ev = random_event();
			offer(ev);
			predict_event(ev);
			if (!quiet && accepted >= TOTAL_ITEMS - QUIET_ITEMS)
				quiet <= 1'b1;
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (pending_results.size() != 0)
			note_fault($sformatf("%0d expected results never arrived", pending_results.size()));

		$display("%0d link events accepted (%0d directed), %0d result transactions checked",
			accepted, stim_rows.size(), checked);
		$display("%0d in-order deliveries, %0d timer stops, one %0d-cycle receiver hold-off",
			n_deliver, n_stop, LONG_HOLD);
		if (faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin : result_sink
		arq_result_t got;
		arq_result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			got = {action, seq_num, ack_num, slot, network_enable, last};
			checked++;
			if (got.action == srarq_pkg::ACT_DELIVER)
				n_deliver++;
			if (got.action == srarq_pkg::ACT_STOP)
				n_stop++;
			if (pending_results.size() == 0) begin
				note_fault($sformatf("unexpected result act=%0d seq=%0d ack=%0d slot=%0d ne=%0d last=%0d",
					got.action, got.seq, got.ack, got.slot, got.ne, got.last));
			end else begin
				exp = pending_results.pop_front();
				if (got.action !== exp.action || got.seq !== exp.seq || got.ack !== exp.ack ||
						got.slot !== exp.slot || got.ne !== exp.ne || got.last !== exp.last)
					note_fault($sformatf({"result %0d: exp act=%0d seq=%0d ack=%0d slot=%0d ",
						"ne=%0d last=%0d, got act=%0d seq=%0d ack=%0d slot=%0d ne=%0d last=%0d"},
						checked, exp.action, exp.seq, exp.ack, exp.slot, exp.ne, exp.last,
						got.action, got.seq, got.ack, got.slot, got.ne, got.last));
			end
		end
		// hold off once for long enough that the engine backs up onto its input
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!long_done && checked >= HOLD_AFTER) begin
			long_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 18) begin
			hold_left = $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d results still expected",
				cycles, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

### sim.f
+incdir+rtl
rtl/srarq_pkg.sv
rtl/srarq_ctrl.sv
rtl/srarq_dp.sv
rtl/selective_repeat_arq_control_top.sv
dv/selective_repeat_arq_control_tb.sv
